/* src/wsu_pkg.sv */
// Shared types and codes for the websocket frame unmasker.
package wsu_pkg;

  typedef enum logic [4:0] {
    PH_SKIP = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_MASK = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_NO_FIN  = 2'd1,
    ST_NO_MASK = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

endpackage

/* src/wsu_if.sv */
// Valid/ready stream interfaces for received bytes and unmasked results.
interface wsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface wsu_out_if import wsu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;
  status_t    status;

  modport source (output valid, output payload_byte, output last_byte, output status,
                  input ready);
  modport sink (input valid, input payload_byte, input last_byte, input status,
                output ready);
endinterface

/* src/websocket_frame_unmasker_core.sv */
// Websocket client frame unmasker: header parse, mask capture, payload XOR.
// The result of an accepted byte is registered in the output register.
// Throughput: one byte per cycle while results drain; the input stalls while
// a result waits, so a byte is taken whenever the result slot is empty or drains.
// Reset (rst, synchronous): parser skips until a frame start, output slot empties.
module websocket_frame_unmasker_core import wsu_pkg::*; #(
  parameter int LEN_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst,
  wsu_in_if.sink    rx,
  wsu_out_if.source pl
);

  localparam int LenW = 8 * LEN_BYTES;

  phase_t          phase, phase_next;
  logic [LenW-1:0] remaining_length, remaining_length_next;
  logic [3:0]      header_byte_count, header_byte_count_next;
  logic [31:0]     mask_key, mask_key_next;
  logic [1:0]      mask_index, mask_index_next;

  logic            res_valid;
  logic [7:0]      res_data;
  logic            res_last;
  status_t         res_status;
  logic [7:0]      key_byte;
  logic [3:0]      hbc_dec;
  logic            in_fire;

  logic            out_valid;
  logic [7:0]      out_data;
  logic            out_last;
  status_t         out_status;

  assign rx.ready = !out_valid || pl.ready;
  assign in_fire  = rx.valid && rx.ready;
  assign hbc_dec  = header_byte_count - 4'd1;

  always_comb begin
    case (mask_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next             = phase;
    remaining_length_next  = remaining_length;
    header_byte_count_next = header_byte_count;
    mask_key_next          = mask_key;
    mask_index_next        = mask_index;
    res_valid              = 1'b0;
    res_data               = 8'd0;
    res_last               = 1'b0;
    res_status             = ST_DATA;
    if (rx.frame_start) begin
      remaining_length_next  = '0;
      header_byte_count_next = 4'd0;
      mask_key_next          = 32'd0;
      mask_index_next        = 2'd0;
      if (!rx.rx_byte[7]) begin
        phase_next = PH_SKIP;
        res_valid  = 1'b1;
        res_last   = 1'b1;
        res_status = ST_NO_FIN;
      end else begin
        phase_next = PH_LEN;
      end
    end else begin
      case (phase)
        PH_SKIP: begin
          phase_next = PH_SKIP;
        end
        PH_LEN: begin
          if (!rx.rx_byte[7]) begin
            phase_next = PH_SKIP;
            res_valid  = 1'b1;
            res_last   = 1'b1;
            res_status = ST_NO_MASK;
          end else if (rx.rx_byte[6:0] == LEN_CODE_16) begin
            remaining_length_next  = '0;
            header_byte_count_next = 4'd2;
            phase_next             = PH_EXT;
          end else if (rx.rx_byte[6:0] == LEN_CODE_64) begin
            remaining_length_next  = '0;
            header_byte_count_next = 4'(LEN_BYTES);
            phase_next             = PH_EXT;
          end else begin
            remaining_length_next  = LenW'(rx.rx_byte[6:0]);
            header_byte_count_next = MASK_BYTES;
            phase_next             = PH_MASK;
          end
        end
        PH_EXT: begin
          remaining_length_next  = {remaining_length[LenW-9:0], rx.rx_byte};
          header_byte_count_next = hbc_dec;
          if (hbc_dec == 4'd0) begin
            header_byte_count_next = MASK_BYTES;
            phase_next             = PH_MASK;
          end
        end
        PH_MASK: begin
          mask_key_next          = {mask_key[23:0], rx.rx_byte};
          header_byte_count_next = hbc_dec;
          if (hbc_dec == 4'd0) begin
            mask_index_next = 2'd0;
            if (remaining_length == '0) begin
              phase_next = PH_SKIP;
              res_valid  = 1'b1;
              res_last   = 1'b1;
              res_status = ST_EMPTY;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          remaining_length_next = remaining_length - LenW'(1);
          mask_index_next       = mask_index + 2'd1;
          res_valid             = 1'b1;
          res_data              = rx.rx_byte ^ key_byte;
          res_status            = ST_DATA;
          res_last              = (remaining_length == LenW'(1));
          if (remaining_length == LenW'(1)) begin
            phase_next = PH_SKIP;
          end
        end
        default: begin
          phase_next = PH_SKIP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SKIP;
      remaining_length  <= '0;
      header_byte_count <= 4'd0;
      mask_key          <= 32'd0;
      mask_index        <= 2'd0;
    end else if (in_fire) begin
      phase             <= phase_next;
      remaining_length  <= remaining_length_next;
      header_byte_count <= header_byte_count_next;
      mask_key          <= mask_key_next;
      mask_index        <= mask_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (pl.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_data   <= res_data;
      out_last   <= res_last;
      out_status <= res_status;
    end
  end

  assign pl.valid        = out_valid;
  assign pl.payload_byte = out_data;
  assign pl.last_byte    = out_last;
  assign pl.status       = out_status;

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_DATA) |-> (out_data == 8'd0 && out_last))
    else $error("non-payload result must carry zero data and last flag");

  a_no_fin_reject: assert property (@(posedge clk) disable iff (rst)
    (in_fire && rx.frame_start && !rx.rx_byte[7]) |=>
      (out_valid && out_status == ST_NO_FIN))
    else $error("frame start without FIN must give a reject result");

  a_data_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (remaining_length != '0))
    else $error("payload phase with zero remaining length");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !rx.frame_start && phase == PH_DATA && remaining_length == LenW'(1)) |=>
      (phase == PH_SKIP && out_valid && out_last))
    else $error("final payload byte must flag last and end the frame");

endmodule
